// File: rtl/core/kste_pkg.sv
// Shared types and constants for the key state tracker.
`timescale 1ns / 1ps

package kste_pkg;

   // Default sizing, handed to the top level parameters
   localparam int NUM_DEVICES_DEF = 4;
   localparam int LIST_CAP_DEF    = 8;

   // Key vector layout: 256 codes scanned as 32 chunks of 8 bits
   localparam int KEY_CODES   = 256;
   localparam int CHUNK_BITS  = 8;
   localparam int NUM_CHUNKS  = KEY_CODES / CHUNK_BITS;
   localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
   localparam int BIT_IDX_W   = $clog2(CHUNK_BITS);

   localparam logic [7:0] FILLER_CODE = 8'hFF;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Beat widths
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   typedef logic [NUM_CHUNKS-1:0][CHUNK_BITS-1:0] key_row_type;

   typedef enum logic [2:0] {
      RK_STATUS   = 3'd0,
      RK_DOWN     = 3'd1,
      RK_PRESSED  = 3'd2,
      RK_RELEASED = 3'd3,
      RK_SUMMARY  = 3'd4
   } result_kind_type;

   typedef enum logic [1:0] {
      ES_APPLIED  = 2'd0,
      ES_REJECTED = 2'd1,
      ES_FILLER   = 2'd2
   } event_status_type;

   typedef enum logic [1:0] {
      LIST_DOWN,
      LIST_PRESSED,
      LIST_RELEASED
   } list_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUMMARY
   } back_state_type;

   // Classified command, as queued by the front
   typedef struct packed {
      logic        is_tick;
      logic        tick_in_range;
      logic        is_filler;
      logic [31:0] device_id;
      logic [7:0]  vkey_code;
      logic        key_released;
      logic [1:0]  tick_slot;
   } cmd_type;

endpackage

// File: rtl/core/key_state_tracker_with_edge_events_unit.sv
// Top level of the keyboard state tracker with press and release edge reporting.
`timescale 1ns / 1ps

// Tracks the 256-key state of up to NUM_DEVICES keyboards, keyed by a 32-bit
// device id that claims a free slot on first sight. A key event beat (tuser 0)
// gives one status beat; a snapshot tick (tuser 1) gives the down, just-pressed
// and just-released keys of one slot in ascending code order, at most LIST_CAP
// of each, then a summary beat with tlast, and the slot's snapshot then takes
// the current vector; a tick whose slot is out of range gives only a summary
// beat with zero counts. Beats pass the front end into a two-entry command
// queue, so the input keeps accepting until the queue is full while the back
// end works or the result stalls. Key events sustain one per cycle while the
// result side takes every beat, each passing the queue and the result register.
// A tick scans the slot's vector eight codes per cycle while no listed key or
// stall holds it; each of the three lists emits one beat per listed key and
// stops early once LIST_CAP keys are listed, before the summary beat.
module key_state_tracker_with_edge_events_unit #(
   parameter int NUM_DEVICES = kste_pkg::NUM_DEVICES_DEF,
   parameter int LIST_CAP    = kste_pkg::LIST_CAP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] device_id, [39:32] vkey_code, [40] key_released, [42:41] tick_slot
   input  logic [kste_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] event_status, [3:2] slot_index, [11:4] listed_key,
   // [15:12] down_total, [19:16] pressed_total, [23:20] released_total
   output logic [kste_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [2:0] result_kind
   output logic [kste_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast
);
   import kste_pkg::*;

   cmd_type head_cmd;
   logic    head_valid;
   logic    head_pop;

   kste_front #(
      .NUM_DEVICES (NUM_DEVICES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   kste_back #(
      .NUM_DEVICES (NUM_DEVICES),
      .LIST_CAP    (LIST_CAP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/core/kste_front.sv
// Front end: accepts request beats, classifies them and queues commands.
`timescale 1ns / 1ps

module kste_front #(
   parameter int NUM_DEVICES = kste_pkg::NUM_DEVICES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] device_id, [39:32] vkey_code, [40] key_released, [42:41] tick_slot
   input  logic [kste_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                             req_tuser,
   output kste_pkg::cmd_type                head_cmd,
   output logic                             head_valid,
   input  logic                             head_pop
);
   import kste_pkg::*;

   cmd_type           cmd_new;
   cmd_type           q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic              push;

   // Classify the incoming beat
   always_comb begin
      cmd_new.is_tick       = req_tuser;
      cmd_new.device_id     = req_tdata[31:0];
      cmd_new.vkey_code     = req_tdata[39:32];
      cmd_new.key_released = req_tdata[40];
      cmd_new.tick_slot     = req_tdata[42:41];
      cmd_new.tick_in_range = (32'(req_tdata[42:41]) < 32'(NUM_DEVICES));
      cmd_new.is_filler     = (req_tdata[39:32] == FILLER_CODE);
   end

   assign req_tready = (q_cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (q_cnt_ff != '0);
   assign head_cmd   = q_mem_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push && !head_pop) begin
         q_cnt_in = q_cnt_ff + QCNT_W'(1);
      end else if (!push && head_pop) begin
         q_cnt_in = q_cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: rtl/core/kste_back.sv
// Back end: device table, key vectors, snapshot scan and result register.
`timescale 1ns / 1ps

module kste_back #(
   parameter int NUM_DEVICES = kste_pkg::NUM_DEVICES_DEF,
   parameter int LIST_CAP    = kste_pkg::LIST_CAP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kste_pkg::cmd_type                head_cmd,
   input  logic                             head_valid,
   output logic                             head_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] event_status, [3:2] slot_index, [11:4] listed_key,
   // [15:12] down_total, [19:16] pressed_total, [23:20] released_total
   output logic [kste_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [2:0] result_kind
   output logic [kste_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast
);
   import kste_pkg::*;

   localparam int SLOT_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int USED_W = $clog2(NUM_DEVICES + 1);
   localparam int CNT_W  = $clog2(LIST_CAP + 1);

   // State
   back_state_type         state_ff, state_in;
   list_kind_type          list_ff, list_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [CHUNK_BITS-1:0]  done_ff, done_in;
   logic [CNT_W-1:0]       dn_cnt_ff, dn_cnt_in;
   logic [CNT_W-1:0]       pr_cnt_ff, pr_cnt_in;
   logic [CNT_W-1:0]       rl_cnt_ff, rl_cnt_in;
   logic [USED_W-1:0]      slots_used_ff;
   logic [31:0]            slot_ids_ff [NUM_DEVICES];
   key_row_type            key_bits_ff [NUM_DEVICES];
   key_row_type            key_snap_ff [NUM_DEVICES];

   // Result register
   logic                   rsp_valid_ff;
   result_kind_type        rsp_kind_ff, rsp_kind_in;
   event_status_type       rsp_status_ff, rsp_status_in;
   logic [1:0]             rsp_slot_ff, rsp_slot_in;
   logic [7:0]             rsp_key_ff, rsp_key_in;
   logic [3:0]             rsp_dn_ff, rsp_dn_in;
   logic [3:0]             rsp_pr_ff, rsp_pr_in;
   logic [3:0]             rsp_rl_ff, rsp_rl_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Lookup and scan signals
   logic                   match_found;
   logic [SLOT_W-1:0]      hit_slot;
   logic [SLOT_W-1:0]      ev_slot;
   logic                   table_full;
   logic                   ev_rejected;
   logic [SLOT_W+1:0]      ev_slot_ext;
   logic [SLOT_W+1:0]      tick_ext;
   logic [SLOT_W-1:0]      tick_idx;
   logic [CHUNK_BITS-1:0]  cur_chunk, prv_chunk, sel_chunk, pending;
   logic [BIT_IDX_W-1:0]   pos;
   logic                   chunk_empty;
   logic [CNT_W-1:0]       cnt_cur;
   logic                   cap_hit;
   logic                   list_done;
   logic                   out_free;
   logic [CNT_W+3:0]       dn_ext, pr_ext, rl_ext;

   // Controls
   logic                   start_scan, emit_event, emit_key, emit_summary;
   logic                   adv_chunk, adv_list, copy_snap, rsp_load;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Device table lookup, lowest matching slot wins
   always_comb begin
      match_found = 1'b0;
      hit_slot    = '0;
      for (int i = NUM_DEVICES - 1; i >= 0; i--) begin
         if ((USED_W'(i) < slots_used_ff) && (slot_ids_ff[i] == head_cmd.device_id)) begin
            match_found = 1'b1;
            hit_slot    = SLOT_W'(i);
         end
      end
   end

   assign table_full  = (slots_used_ff == USED_W'(NUM_DEVICES));
   assign ev_rejected = !match_found && table_full;
   assign ev_slot     = match_found ? hit_slot : slots_used_ff[SLOT_W-1:0];
   assign ev_slot_ext = {2'b00, ev_slot};
   assign tick_ext    = {{SLOT_W{1'b0}}, head_cmd.tick_slot};
   assign tick_idx    = tick_ext[SLOT_W-1:0];

   // Chunk under scan and its lowest pending bit
   assign cur_chunk = key_bits_ff[tick_idx][chunk_ff];
   assign prv_chunk = key_snap_ff[tick_idx][chunk_ff];

   always_comb begin
      case (list_ff)
         LIST_DOWN:    sel_chunk = cur_chunk;
         LIST_PRESSED: sel_chunk = cur_chunk & ~prv_chunk;
         default:      sel_chunk = prv_chunk & ~cur_chunk;
      endcase
      case (list_ff)
         LIST_DOWN:    cnt_cur = dn_cnt_ff;
         LIST_PRESSED: cnt_cur = pr_cnt_ff;
         default:      cnt_cur = rl_cnt_ff;
      endcase
   end

   assign pending     = sel_chunk & ~done_ff;
   assign chunk_empty = (pending == '0);
   assign cap_hit     = (cnt_cur == CNT_W'(LIST_CAP));
   assign list_done   = cap_hit || (chunk_empty && (chunk_ff == CHUNK_IDX_W'(NUM_CHUNKS - 1)));

   always_comb begin
      pos = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         if (pending[i]) begin
            pos = BIT_IDX_W'(i);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && head_cmd.is_tick && head_cmd.tick_in_range) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (list_done && (list_ff == LIST_RELEASED)) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      start_scan   = 1'b0;
      emit_event   = 1'b0;
      emit_key     = 1'b0;
      emit_summary = 1'b0;
      adv_chunk    = 1'b0;
      adv_list     = 1'b0;
      copy_snap    = 1'b0;
      head_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_cmd.is_tick && head_cmd.tick_in_range) begin
                  start_scan = 1'b1;
               end else if (out_free) begin
                  emit_event   = !head_cmd.is_tick;
                  emit_summary = head_cmd.is_tick;
                  head_pop     = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (list_done) begin
               adv_list = 1'b1;
            end else if (chunk_empty) begin
               adv_chunk = 1'b1;
            end else if (out_free) begin
               emit_key = 1'b1;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               emit_summary = 1'b1;
               copy_snap    = 1'b1;
               head_pop     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Scan bookkeeping
   always_comb begin
      list_in   = list_ff;
      chunk_in  = chunk_ff;
      done_in   = done_ff;
      dn_cnt_in = dn_cnt_ff;
      pr_cnt_in = pr_cnt_ff;
      rl_cnt_in = rl_cnt_ff;
      if (start_scan) begin
         list_in   = LIST_DOWN;
         chunk_in  = '0;
         done_in   = '0;
         dn_cnt_in = '0;
         pr_cnt_in = '0;
         rl_cnt_in = '0;
      end else if (adv_list) begin
         chunk_in = '0;
         done_in  = '0;
         case (list_ff)
            LIST_DOWN:    list_in = LIST_PRESSED;
            default:      list_in = LIST_RELEASED;
         endcase
      end else if (adv_chunk) begin
         chunk_in = chunk_ff + CHUNK_IDX_W'(1);
         done_in  = '0;
      end else if (emit_key) begin
         done_in = done_ff | (CHUNK_BITS'(1) << pos);
         case (list_ff)
            LIST_DOWN:    dn_cnt_in = dn_cnt_ff + CNT_W'(1);
            LIST_PRESSED: pr_cnt_in = pr_cnt_ff + CNT_W'(1);
            default:      rl_cnt_in = rl_cnt_ff + CNT_W'(1);
         endcase
      end
   end

   assign dn_ext = {4'b0000, dn_cnt_ff};
   assign pr_ext = {4'b0000, pr_cnt_ff};
   assign rl_ext = {4'b0000, rl_cnt_ff};

   // Result beat contents
   always_comb begin
      rsp_load      = emit_event || emit_key || emit_summary;
      rsp_kind_in   = RK_STATUS;
      rsp_status_in = ES_APPLIED;
      rsp_slot_in   = head_cmd.tick_slot;
      rsp_key_in    = '0;
      rsp_dn_in     = '0;
      rsp_pr_in     = '0;
      rsp_rl_in     = '0;
      rsp_last_in   = 1'b1;
      if (emit_event) begin
         if (ev_rejected) begin
            rsp_status_in = ES_REJECTED;
            rsp_slot_in   = '0;
         end else begin
            rsp_status_in = head_cmd.is_filler ? ES_FILLER : ES_APPLIED;
            rsp_slot_in   = ev_slot_ext[1:0];
         end
      end else if (emit_key) begin
         case (list_ff)
            LIST_DOWN:    rsp_kind_in = RK_DOWN;
            LIST_PRESSED: rsp_kind_in = RK_PRESSED;
            default:      rsp_kind_in = RK_RELEASED;
         endcase
         rsp_key_in  = {chunk_ff, pos};
         rsp_last_in = 1'b0;
      end else begin
         rsp_kind_in = RK_SUMMARY;
         // out-of-range ticks report zero counts
         if (state_ff == ST_SUMMARY) begin
            rsp_dn_in = dn_ext[3:0];
            rsp_pr_in = pr_ext[3:0];
            rsp_rl_in = rl_ext[3:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         list_ff       <= LIST_DOWN;
         chunk_ff      <= '0;
         done_ff       <= '0;
         dn_cnt_ff     <= '0;
         pr_cnt_ff     <= '0;
         rl_cnt_ff     <= '0;
         slots_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         list_ff   <= list_in;
         chunk_ff  <= chunk_in;
         done_ff   <= done_in;
         dn_cnt_ff <= dn_cnt_in;
         pr_cnt_ff <= pr_cnt_in;
         rl_cnt_ff <= rl_cnt_in;
         if (emit_event && !ev_rejected && !match_found) begin
            slots_used_ff <= slots_used_ff + USED_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Key vectors and snapshots, all keys up after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DEVICES; i++) begin
            key_bits_ff[i] <= '0;
            key_snap_ff[i] <= '0;
         end
      end else begin
         if (emit_event && !ev_rejected && !head_cmd.is_filler) begin
            key_bits_ff[ev_slot][head_cmd.vkey_code[BIT_IDX_W +: CHUNK_IDX_W]]
                       [head_cmd.vkey_code[BIT_IDX_W-1:0]] <= !head_cmd.key_released;
         end
         if (copy_snap) begin
            key_snap_ff[tick_idx] <= key_bits_ff[tick_idx];
         end
      end
   end

   // Device ids, meaningful only below the used count
   always_ff @(posedge clock) begin
      if (emit_event && !ev_rejected && !match_found) begin
         slot_ids_ff[ev_slot] <= head_cmd.device_id;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_dn_ff     <= rsp_dn_in;
         rsp_pr_ff     <= rsp_pr_in;
         rsp_rl_ff     <= rsp_rl_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_rl_ff, rsp_pr_ff, rsp_dn_ff, rsp_key_ff, rsp_slot_ff, rsp_status_ff};

endmodule
